[rtl/core/ptbr_pkg.sv]
// Package: shared types, character folding and the per-character coding rules.
package ptbr_pkg;

    localparam int CP_W = 21;
    localparam int QUEUE_DEPTH = 8;

    typedef logic [CP_W-1:0] t_cp;

    typedef struct packed {
        logic [6:0] sym;
        logic       vld;
        logic       last;
    } t_ent;

    typedef struct packed {
        logic [1:0] cnt;
        t_ent       e0;
        t_ent       e1;
    } t_push;

    typedef struct packed {
        logic [1:0] cnt;
        logic [6:0] s0;
        logic [6:0] s1;
        logic [1:0] skip;
    } t_code;

    localparam t_cp CH_A = 21'h41;
    localparam t_cp CH_C = 21'h43;
    localparam t_cp CH_E = 21'h45;
    localparam t_cp CH_G = 21'h47;
    localparam t_cp CH_H = 21'h48;
    localparam t_cp CH_I = 21'h49;
    localparam t_cp CH_K = 21'h4B;
    localparam t_cp CH_L = 21'h4C;
    localparam t_cp CH_N = 21'h4E;
    localparam t_cp CH_O = 21'h4F;
    localparam t_cp CH_P = 21'h50;
    localparam t_cp CH_Q = 21'h51;
    localparam t_cp CH_R = 21'h52;
    localparam t_cp CH_S = 21'h53;
    localparam t_cp CH_T = 21'h54;
    localparam t_cp CH_U = 21'h55;
    localparam t_cp CH_X = 21'h58;

    localparam logic [6:0] SY_LH = 7'h31;
    localparam logic [6:0] SY_RR = 7'h32;
    localparam logic [6:0] SY_NH = 7'h33;

    function automatic t_cp upcase(t_cp c);
        t_cp r;
        r = c;
        if (c >= 21'h61 && c <= 21'h7A) r = c - 21'h20;
        else if (c == 21'hB5) r = 21'h39C;
        else if (c >= 21'hE0 && c <= 21'hFE && c != 21'hF7) r = c - 21'h20;
        else if (c == 21'hFF) r = 21'h178;
        else if (c == 21'h131) r = 21'h49;
        else if (c == 21'h17F) r = 21'h53;
        else if (c >= 21'h100 && c <= 21'h137 && c[0]) r = c - 21'h1;
        else if (c >= 21'h139 && c <= 21'h148 && !c[0]) r = c - 21'h1;
        else if (c >= 21'h14A && c <= 21'h177 && c[0]) r = c - 21'h1;
        else if (c >= 21'h17A && c <= 21'h17E && !c[0]) r = c - 21'h1;
        else if (c >= 21'h1E00 && c <= 21'h1E95 && c[0]) r = c - 21'h1;
        else if (c >= 21'h1EA0 && c <= 21'h1EFF && c[0]) r = c - 21'h1;
        return r;
    endfunction

    function automatic t_cp fold_char(t_cp d);
        t_cp c;
        c = upcase(d);
        case (c) inside
            21'hC1, 21'hC0, 21'hC3, 21'hC2, 21'hC4: c = CH_A;
            21'hC9, 21'hC8, 21'h1EBC, 21'hCA, 21'hCB: c = CH_E;
            21'h59, 21'hCD, 21'hCC, 21'h128, 21'hCE, 21'hCF: c = CH_I;
            21'hD3, 21'hD2, 21'hD5, 21'hD4, 21'hD6: c = CH_O;
            21'hDA, 21'hD9, 21'h168, 21'hDB, 21'hDC: c = CH_U;
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic is_vow(t_cp c);
        return c == CH_A || c == CH_E || c == CH_I || c == CH_O || c == CH_U;
    endfunction

    function automatic logic is_edge(t_cp c);
        return c == 21'h0 || c == 21'h20 || (c >= 21'h9 && c <= 21'hD);
    endfunction

    function automatic t_code mk(logic [1:0] n, logic [6:0] a, logic [6:0] b,
                                 logic [1:0] sk);
        t_code r;
        r.cnt = n;
        r.s0 = a;
        r.s1 = b;
        r.skip = sk;
        return r;
    endfunction

    // Coding of one head character given its neighbors.
    function automatic t_code code_one(t_cp c, t_cp a1, t_cp a2, t_cp last, t_cp l2);
        t_code r;
        logic [6:0] c7;
        r = '0;
        c7 = c[6:0];
        case (c) inside
            21'h41, 21'h45, 21'h49, 21'h4F, 21'h55: begin
                if (is_edge(last)) r = mk(2'd1, c7, 7'h0, 2'd0);
            end
            21'h4C: begin
                if (a1 == CH_H) r = mk(2'd1, SY_LH, 7'h0, 2'd0);
                else if (is_vow(a1) || is_edge(last)) r = mk(2'd1, 7'h4C, 7'h0, 2'd0);
            end
            21'h54, 21'h50: begin
                if (a1 == CH_H) r = mk(2'd1, (c == CH_P) ? 7'h46 : 7'h54, 7'h0, 2'd1);
                else r = mk(2'd1, c7, 7'h0, 2'd0);
            end
            21'h42, 21'h44, 21'h46, 21'h4A, 21'h4B, 21'h4D, 21'h56: begin
                r = mk(2'd1, c7, 7'h0, 2'd0);
            end
            21'h47: begin
                if (a1 == CH_H) begin
                    if (!is_vow(a2)) r = mk(2'd2, 7'h47, 7'h4A, 2'd0);
                    else r = mk(2'd1, 7'h4A, 7'h0, 2'd0);
                end else if (a1 == CH_E || a1 == CH_I) r = mk(2'd1, 7'h4A, 7'h0, 2'd0);
                else r = mk(2'd1, 7'h47, 7'h0, 2'd0);
            end
            21'h52: begin
                if (is_edge(last) || is_edge(a1)) r = mk(2'd1, SY_RR, 7'h0, 2'd0);
                else if (a1 == CH_R) r = mk(2'd1, SY_RR, 7'h0, 2'd1);
                else if (is_vow(last) && is_vow(a1)) r = mk(2'd1, 7'h52, 7'h0, 2'd1);
                else r = mk(2'd1, 7'h52, 7'h0, 2'd0);
            end
            21'h5A: begin
                r = mk(2'd1, is_edge(a1) ? 7'h53 : 7'h5A, 7'h0, 2'd0);
            end
            21'h4E: begin
                if (is_edge(a1)) r = mk(2'd1, 7'h4D, 7'h0, 2'd0);
                else if (a1 == CH_H) r = mk(2'd1, SY_NH, 7'h0, 2'd1);
                else if (last != CH_N) r = mk(2'd1, 7'h4E, 7'h0, 2'd0);
            end
            21'h53: begin
                if (a1 == CH_S) r = mk(2'd1, 7'h53, 7'h0, 2'd1);
                else if (a1 == CH_H) r = mk(2'd1, 7'h58, 7'h0, 2'd1);
                else if (is_vow(last) && is_vow(a1)) r = mk(2'd1, 7'h5A, 7'h0, 2'd0);
                else if (a1 == CH_C) begin
                    if (a2 == CH_E || a2 == CH_I) r = mk(2'd1, 7'h53, 7'h0, 2'd2);
                    else if (a2 == CH_A || a2 == CH_O || a2 == CH_U)
                        r = mk(2'd2, 7'h53, 7'h4B, 2'd2);
                    else if (a2 == CH_H) r = mk(2'd1, 7'h58, 7'h0, 2'd2);
                    else r = mk(2'd1, 7'h53, 7'h0, 2'd1);
                end else r = mk(2'd1, 7'h53, 7'h0, 2'd0);
            end
            21'h58: begin
                if (is_edge(a1)) r = mk(2'd1, 7'h58, 7'h0, 2'd0);
                else if (last == CH_E) begin
                    if (is_vow(a1)) begin
                        if (is_edge(l2)) r = mk(2'd1, 7'h5A, 7'h0, 2'd0);
                        else if (a1 == CH_E || a1 == CH_I) r = mk(2'd1, 7'h58, 7'h0, 2'd1);
                        else r = mk(2'd2, 7'h4B, 7'h53, 2'd1);
                    end else if (a1 == CH_C) r = mk(2'd1, 7'h53, 7'h0, 2'd1);
                    else if (a1 == CH_P || a1 == CH_T) r = mk(2'd1, 7'h53, 7'h0, 2'd0);
                    else r = mk(2'd2, 7'h4B, 7'h53, 2'd0);
                end else if (is_vow(last)) begin
                    if (is_vow(l2) || l2 == CH_C || l2 == CH_K || l2 == CH_G ||
                        l2 == CH_L || l2 == CH_R || l2 == CH_X)
                        r = mk(2'd1, 7'h58, 7'h0, 2'd0);
                    else r = mk(2'd2, 7'h4B, 7'h53, 2'd0);
                end else r = mk(2'd1, 7'h58, 7'h0, 2'd0);
            end
            21'h43: begin
                if (a1 == CH_E || a1 == CH_I) r = mk(2'd1, 7'h53, 7'h0, 2'd0);
                else if (a1 == CH_H) r = mk(2'd1, (a2 == CH_R) ? 7'h4B : 7'h58, 7'h0, 2'd1);
                else if (a1 == CH_Q || a1 == CH_K) r = '0;
                else r = mk(2'd1, 7'h4B, 7'h0, 2'd0);
            end
            21'h48: begin
                if (is_edge(last) && is_vow(a1)) r = mk(2'd1, a1[6:0], 7'h0, 2'd1);
            end
            21'h51: r = mk(2'd1, 7'h4B, 7'h0, 2'd0);
            21'h57: begin
                if (is_vow(a1)) r = mk(2'd1, 7'h56, 7'h0, 2'd0);
            end
            21'hC7: r = mk(2'd1, 7'h53, 7'h0, 2'd0);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/ptbr_if.sv]
// Interfaces: input character channel and output code symbol channel.
interface ptbr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_point;
    logic        string_end;
    modport source (output valid, output code_point, output string_end, input ready);
    modport sink (input valid, input code_point, input string_end, output ready);
endinterface

interface ptbr_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] code_char;
    logic       char_valid;
    logic       code_last;
    modport source (output valid, output code_char, output char_valid, output code_last,
                    input ready);
    modport sink (input valid, input code_char, input char_valid, input code_last,
                  output ready);
endinterface

[rtl/core/phonetic_code_ptbr.sv]
// Top level: Brazilian Portuguese phonetic coder, characters in, code symbols out.
//  channel  | dir | payload
//  i_in     | in  | code_point[15:0], string_end
//  o_out    | out | code_char[6:0], char_valid, code_last
// A character is taken when the queue has room; a string-end item holds off further
// input while the lookahead window drains one character a cycle, room allowing.
// Up to two symbols are queued per cycle, one leaves per cycle; a stalled output
// fills the eight-entry queue until under two entries are free, then input stops.
// Synchronous active-low reset empties the input register, window and queue.
module phonetic_code_ptbr #(
    parameter int CHAR_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptbr_in_if.sink     i_in,
    ptbr_out_if.source  o_out
);
    import ptbr_pkg::*;

    t_push push;
    logic  room;

    ptbr_coder #(.CHAR_WIDTH(CHAR_WIDTH)) u_coder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (push),
        .i_room  (room)
    );

    ptbr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

[rtl/core/ptbr_coder.sv]
// Coder: input register, fold and dedup, lookahead window and rule evaluation.
module ptbr_coder #(
    parameter int CHAR_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ptbr_in_if.sink          i_in,
    output ptbr_pkg::t_push  o_push,
    input  logic             i_room
);
    import ptbr_pkg::*;

    localparam logic M_NORMAL = 1'b0;
    localparam logic M_DRAIN  = 1'b1;

    typedef logic [CHAR_WIDTH-1:0] t_ch;

    logic        r_in_vld, r_in_end;
    logic [15:0] r_in_cp;
    logic        r_mode, n_mode;
    t_ch         r_prev_f, n_prev_f;
    logic        r_rep, n_rep;
    t_ch         r_win [3];
    t_ch         n_win [3];
    logic [1:0]  r_fill, n_fill;
    t_ch         r_hist0, n_hist0, r_hist1, n_hist1;
    t_ch         r_head, n_head;
    logic [1:0]  r_skip, n_skip;
    logic        r_hv, n_hv;
    logic [6:0]  r_held, n_held;

    logic  take, drain_go, endm, do_cons, finish;
    t_ch   cpn, fn;
    logic  same, keep;
    t_code cd;
    t_push pu;

    assign take     = r_in_vld && (r_mode == M_NORMAL) && i_room;
    assign drain_go = (r_mode == M_DRAIN) && i_room;
    assign i_in.ready = !r_in_vld || take;
    assign endm     = (take && r_in_end) || (r_mode == M_DRAIN);
    assign finish   = drain_go && (r_fill == 2'd0);

    always_comb begin
        n_mode = r_mode;
        n_prev_f = r_prev_f;
        n_rep = r_rep;
        n_win = r_win;
        n_fill = r_fill;
        n_hist0 = r_hist0;
        n_hist1 = r_hist1;
        n_head = r_head;
        n_skip = r_skip;
        n_hv = r_hv;
        n_held = r_held;
        cpn = t_ch'(t_cp'(r_in_cp));
        fn = t_ch'(fold_char(t_cp'(cpn)));
        same = (fn == r_prev_f);
        keep = same ? ((t_cp'(fn) == CH_R || t_cp'(fn) == CH_S) && !r_rep) : 1'b1;
        cd = '0;
        pu = '0;
        do_cons = 1'b0;

        if (take && cpn != '0) begin
            n_prev_f = fn;
            n_rep = same ? (r_rep | keep) : 1'b0;
            if (keep) begin
                unique case (r_fill)
                    2'd0: n_win[0] = fn;
                    2'd1: n_win[1] = fn;
                    2'd2: n_win[2] = fn;
                    default: ;
                endcase
                if (r_fill != 2'd3) n_fill = r_fill + 2'd1;
            end
        end

        if (take) do_cons = (n_fill == 2'd3) || (r_in_end && n_fill != 2'd0);
        else if (drain_go) do_cons = (r_fill != 2'd0);

        if (do_cons) begin
            if (r_skip != 2'd0) begin
                n_skip = r_skip - 2'd1;
            end else begin
                cd = code_one(t_cp'(n_win[0]), t_cp'(n_win[1]), t_cp'(n_win[2]),
                              t_cp'(r_head), t_cp'(r_hist1));
                n_skip = cd.skip;
                n_head = n_win[0];
            end
            n_hist1 = r_hist0;
            n_hist0 = n_win[0];
            n_win[0] = n_win[1];
            n_win[1] = n_win[2];
            n_win[2] = '0;
            n_fill = n_fill - 2'd1;
        end

        if (!endm) begin
            pu.cnt = cd.cnt;
            pu.e0 = '{sym: cd.s0, vld: 1'b1, last: 1'b0};
            pu.e1 = '{sym: cd.s1, vld: 1'b1, last: 1'b0};
        end else if (r_hv) begin
            // held symbol goes out ahead of the new ones; the newest is held back
            pu.e0 = '{sym: r_held, vld: 1'b1, last: 1'b0};
            pu.e1 = '{sym: cd.s0, vld: 1'b1, last: 1'b0};
            pu.cnt = cd.cnt;
            if (cd.cnt == 2'd1) n_held = cd.s0;
            else if (cd.cnt == 2'd2) n_held = cd.s1;
        end else begin
            pu.e0 = '{sym: cd.s0, vld: 1'b1, last: 1'b0};
            if (cd.cnt == 2'd1) begin
                n_hv = 1'b1;
                n_held = cd.s0;
            end else if (cd.cnt == 2'd2) begin
                pu.cnt = 2'd1;
                n_hv = 1'b1;
                n_held = cd.s1;
            end
        end

        if (take && r_in_end) n_mode = M_DRAIN;

        if (finish) begin
            pu.cnt = 2'd1;
            pu.e0 = r_hv ? '{sym: r_held, vld: 1'b1, last: 1'b1}
                         : '{sym: 7'h0, vld: 1'b0, last: 1'b1};
            n_mode = M_NORMAL;
            n_prev_f = '0;
            n_rep = 1'b0;
            n_win[0] = '0;
            n_win[1] = '0;
            n_win[2] = '0;
            n_fill = 2'd0;
            n_hist0 = '0;
            n_hist1 = '0;
            n_head = '0;
            n_skip = 2'd0;
            n_hv = 1'b0;
        end
    end

    assign o_push = pu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_mode <= M_NORMAL;
            r_prev_f <= '0;
            r_rep <= 1'b0;
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
            r_fill <= 2'd0;
            r_hist0 <= '0;
            r_hist1 <= '0;
            r_head <= '0;
            r_skip <= 2'd0;
            r_hv <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) r_in_vld <= 1'b1;
            else if (take) r_in_vld <= 1'b0;
            r_mode <= n_mode;
            r_prev_f <= n_prev_f;
            r_rep <= n_rep;
            r_win <= n_win;
            r_fill <= n_fill;
            r_hist0 <= n_hist0;
            r_hist1 <= n_hist1;
            r_head <= n_head;
            r_skip <= n_skip;
            r_hv <= n_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cp <= i_in.code_point;
            r_in_end <= i_in.string_end;
        end
        r_held <= n_held;
    end

    a_fill_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_NORMAL |-> r_fill != 2'd3) else $error("window full between items");
    a_skip_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip <= r_fill) else $error("skip beyond window");
    a_held_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hv |-> r_mode == M_DRAIN) else $error("held symbol outside drain");
    a_finish_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_fill == 2'd0 && r_skip == 2'd0 && !r_hv)
        else $error("state not cleared after string end");

endmodule

[rtl/core/ptbr_outq.sv]
// Output queue: eight-entry symbol queue, up to two writes and one read per cycle.
module ptbr_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptbr_pkg::t_push i_push,
    output logic            o_room,
    ptbr_out_if.source      o_out
);
    import ptbr_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_ent          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          pop;

    assign pop = o_out.valid && o_out.ready;
    assign o_room = r_cnt <= (AW+1)'(QUEUE_DEPTH - 2);
    assign o_out.valid = r_cnt != '0;
    assign o_out.code_char = r_mem[r_rp].sym;
    assign o_out.char_valid = r_mem[r_rp].vld;
    assign o_out.code_last = r_mem[r_rp].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= r_wp + AW'(i_push.cnt);
            if (pop) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push.cnt) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wp] <= i_push.e0;
        if (i_push.cnt == 2'd2) r_mem[r_wp + AW'(1)] <= i_push.e1;
    end

endmodule
